// File: design/frame_interpolation_slot_scheduler_unit_assert.svh
// assertion macros used by the checker file
`ifndef FRAME_INTERPOLATION_SLOT_SCHEDULER_UNIT_ASSERT_SVH
`define FRAME_INTERPOLATION_SLOT_SCHEDULER_UNIT_ASSERT_SVH

// plain property, sampled on the rising clock edge, off while reset is low
`define FISS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// a stalled beat keeps its valid and its payload
`define FISS_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

// File: design/fiss_pkg.sv
package fiss_pkg;

  localparam int QUEUE_DEPTH = 3;
  localparam int CNT_WIDTH   = 32;
  localparam int DIM_WIDTH   = 12;

  localparam int GEN_W    = 32;
  localparam int IDX_W    = 32;
  localparam int HANDLE_W = 32;
  localparam int BYTES_W  = 25;
  localparam int STAT_W   = 32;
  localparam int NUM_CTR  = 5;

  localparam int Q_CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PROD_W  = 2 * DIM_WIDTH + 1;
  localparam int CMP_W   = (PROD_W > BYTES_W) ? PROD_W : BYTES_W;

  typedef enum logic [2:0] {
    OP_CREATE   = 3'd0,
    OP_DESTROY  = 3'd1,
    OP_SUBMIT   = 3'd2,
    OP_SLOT     = 3'd3,
    OP_COMPLETE = 3'd4,
    OP_PAUSE    = 3'd5,
    OP_STATUS   = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    SLOT_SUSPEND = 3'd0,
    SLOT_NATIVE  = 3'd1,
    SLOT_PRIME   = 3'd2,
    SLOT_SOURCE  = 3'd3,
    SLOT_SYNTH   = 3'd4
  } slot_kind_e;

  typedef enum logic [2:0] {
    STAT_DROPPED = 3'd0,
    STAT_SOURCE  = 3'd1,
    STAT_PAIRS   = 3'd2,
    STAT_SYNTH   = 3'd3,
    STAT_HOLD    = 3'd4,
    STAT_GEN     = 3'd5,
    STAT_FLAGS   = 3'd6
  } status_sel_e;

  typedef enum logic [2:0] {
    CTR_DROPPED = 3'd0,
    CTR_SOURCE  = 3'd1,
    CTR_PAIRS   = 3'd2,
    CTR_SYNTH   = 3'd3,
    CTR_HOLD    = 3'd4
  } ctr_e;

  typedef struct packed {
    logic [IDX_W-1:0]     index;
    logic [HANDLE_W-1:0]  handle;
    logic [DIM_WIDTH-1:0] width;
    logic [DIM_WIDTH-1:0] height;
  } frame_t;

  typedef struct packed {
    logic [2:0]           opcode;
    logic [GEN_W-1:0]     generation;
    logic [IDX_W-1:0]     seq_index;
    logic [DIM_WIDTH-1:0] width;
    logic [DIM_WIDTH-1:0] height;
    logic [BYTES_W-1:0]   payload_bytes;
    logic [HANDLE_W-1:0]  frame_handle;
    logic                 flag;
    logic                 presented;
    logic [2:0]           decision_kind;
    logic [2:0]           status_select;
  } req_t;

  typedef struct packed {
    logic                 accepted;
    logic [2:0]           slot_kind;
    logic                 first_valid;
    logic [IDX_W-1:0]     first_index;
    logic [HANDLE_W-1:0]  first_handle;
    logic [DIM_WIDTH-1:0] first_width;
    logic [DIM_WIDTH-1:0] first_height;
    logic [IDX_W-1:0]     second_index;
    logic [HANDLE_W-1:0]  second_handle;
    logic [DIM_WIDTH-1:0] second_width;
    logic [DIM_WIDTH-1:0] second_height;
    logic [STAT_W-1:0]    status_value;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
    logic trim;
  } queue_cmd_t;

  typedef struct packed {
    logic empty;
    logic pair;
    logic full;
  } queue_stat_t;

  typedef struct packed {
    logic clear;
    logic bump;
    ctr_e sel;
  } ctr_cmd_t;

endpackage

// File: design/fiss_if.sv
interface fiss_req_if import fiss_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fiss_rsp_if import fiss_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/frame_interpolation_slot_scheduler_unit.sv
// frame interpolation slot scheduler: one request beat in, one response beat out per request,
// in order. a request is taken into an input register, decoded against the surface state,
// the three-entry frame queue and the five saturating counters combinationally, and its
// response lands in an output register, so each request passes the input register and then
// the output register, and one request can be taken every cycle while the response side
// keeps up. the rate is set by the one compute stage between the input and output registers,
// where the queue and counter update of a request completes before the next request is
// decoded. a stalled response holds the output register, the input register still takes one
// more request, and then ready drops. no clearing pass after reset: queue entries are only
// read once written.
module frame_interpolation_slot_scheduler_unit import fiss_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  fiss_req_if.sink   req_i,
  fiss_rsp_if.source rsp_o
);

  // pipeline registers
  req_t in_q;
  logic in_valid_q, in_valid_d;
  rsp_t rsp_q, rsp_d;
  logic out_valid_q, out_valid_d;
  logic advance;
  logic in_ready;

  // scheduler state
  logic             ready_q, ready_d;
  logic             pause_q, pause_d;
  logic [GEN_W-1:0] gen_q, gen_d;
  logic             synth_q, synth_d;

  // queue and counters
  queue_cmd_t  q_cmd_raw, q_cmd;
  queue_stat_t q_stat;
  frame_t      q_first, q_second, q_newest, in_frame;
  ctr_cmd_t    c_cmd_raw, c_cmd;
  logic [CNT_WIDTH-1:0] counts [NUM_CTR];

  // decode helpers
  logic                   live;
  logic                   dims_ok, bytes_ok, order_ok, create_ok;
  logic [2*DIM_WIDTH-1:0] area;
  logic [PROD_W-1:0]      bytes_need;

  // the compute stage moves when the output register is free or being drained
  assign advance  = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign in_ready = !in_valid_q || advance;
  assign req_i.ready = in_ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (req_i.valid && in_ready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_frame.index  = in_q.seq_index;
  assign in_frame.handle = in_q.frame_handle;
  assign in_frame.width  = in_q.width;
  assign in_frame.height = in_q.height;

  // rgb565 buffer size, two bytes per pixel
  assign area       = in_q.width * in_q.height;
  assign bytes_need = {area, 1'b0};

  assign live      = ready_q && (in_q.generation == gen_q);
  assign dims_ok   = (in_q.width != '0) && (in_q.height != '0);
  assign bytes_ok  = (CMP_W'(bytes_need) == CMP_W'(in_q.payload_bytes));
  assign order_ok  = q_stat.empty || (in_q.seq_index > q_newest.index);
  // a live surface is only replaced by a strictly newer generation
  assign create_ok = (in_q.generation != '0) && !(ready_q && (in_q.generation <= gen_q));

  always_comb begin
    rsp_d     = '0;
    q_cmd_raw = '0;
    c_cmd_raw = '0;
    c_cmd_raw.sel = CTR_DROPPED;
    ready_d   = ready_q;
    pause_d   = pause_q;
    gen_d     = gen_q;
    synth_d   = synth_q;

    case (op_e'(in_q.opcode))
      OP_CREATE: begin
        if (create_ok) begin
          c_cmd_raw.clear = 1'b1;
          q_cmd_raw.clear = 1'b1;
          pause_d  = 1'b0;
          ready_d  = 1'b1;
          gen_d    = in_q.generation;
          synth_d  = 1'b0;
          rsp_d.accepted = 1'b1;
        end
      end
      OP_DESTROY: begin
        // generation, counters and pause survive a destroy
        if (live) begin
          ready_d  = 1'b0;
          q_cmd_raw.clear = 1'b1;
          synth_d  = 1'b0;
          rsp_d.accepted = 1'b1;
        end
      end
      OP_SUBMIT: begin
        if (dims_ok && bytes_ok && live && order_ok) begin
          q_cmd_raw.push = 1'b1;
          if (q_stat.full) begin
            // oldest frame falls out of the queue
            c_cmd_raw.bump = 1'b1;
            c_cmd_raw.sel  = CTR_DROPPED;
            synth_d = 1'b0;
          end
          rsp_d.accepted = 1'b1;
        end
      end
      OP_SLOT: begin
        if (!live || pause_q) begin
          rsp_d.slot_kind = SLOT_SUSPEND;
        end else if (!in_q.flag) begin
          // no motion: show the newest frame natively and drop the rest
          rsp_d.accepted  = 1'b1;
          rsp_d.slot_kind = SLOT_NATIVE;
          synth_d = 1'b0;
          q_cmd_raw.trim = 1'b1;
          if (!q_stat.empty) begin
            rsp_d.first_valid  = 1'b1;
            rsp_d.first_index  = q_newest.index;
            rsp_d.first_handle = q_newest.handle;
            rsp_d.first_width  = q_newest.width;
            rsp_d.first_height = q_newest.height;
          end
        end else if (!q_stat.pair) begin
          rsp_d.accepted  = 1'b1;
          rsp_d.slot_kind = SLOT_PRIME;
        end else begin
          rsp_d.accepted      = 1'b1;
          rsp_d.first_valid   = 1'b1;
          rsp_d.first_index   = q_first.index;
          rsp_d.first_handle  = q_first.handle;
          rsp_d.first_width   = q_first.width;
          rsp_d.first_height  = q_first.height;
          rsp_d.second_index  = q_second.index;
          rsp_d.second_handle = q_second.handle;
          rsp_d.second_width  = q_second.width;
          rsp_d.second_height = q_second.height;
          c_cmd_raw.bump = 1'b1;
          if (!synth_q) begin
            // source slot, the next one synthesizes between a and b
            rsp_d.slot_kind = SLOT_SOURCE;
            synth_d       = 1'b1;
            c_cmd_raw.sel = CTR_SOURCE;
          end else begin
            rsp_d.slot_kind = SLOT_SYNTH;
            synth_d       = 1'b0;
            q_cmd_raw.pop = 1'b1;
            c_cmd_raw.sel = CTR_PAIRS;
          end
        end
      end
      OP_COMPLETE: begin
        // counted whether or not the surface is still ready
        if ((in_q.decision_kind == SLOT_SYNTH) && (in_q.generation == gen_q)) begin
          c_cmd_raw.bump = 1'b1;
          c_cmd_raw.sel  = (in_q.flag && in_q.presented) ? CTR_SYNTH : CTR_HOLD;
          rsp_d.accepted = 1'b1;
        end
      end
      OP_PAUSE: begin
        pause_d = in_q.flag;
        synth_d = 1'b0;
        rsp_d.accepted = 1'b1;
      end
      OP_STATUS: begin
        rsp_d.accepted = 1'b1;
        case (status_sel_e'(in_q.status_select))
          STAT_DROPPED: rsp_d.status_value = STAT_W'(counts[CTR_DROPPED]);
          STAT_SOURCE:  rsp_d.status_value = STAT_W'(counts[CTR_SOURCE]);
          STAT_PAIRS:   rsp_d.status_value = STAT_W'(counts[CTR_PAIRS]);
          STAT_SYNTH:   rsp_d.status_value = STAT_W'(counts[CTR_SYNTH]);
          STAT_HOLD:    rsp_d.status_value = STAT_W'(counts[CTR_HOLD]);
          STAT_GEN:     rsp_d.status_value = STAT_W'(gen_q);
          STAT_FLAGS:   rsp_d.status_value = STAT_W'({pause_q, ready_q});
          default:      rsp_d.status_value = '0;
        endcase
      end
      default: begin
        // unknown opcode: all-zero response, no state change
      end
    endcase
  end

  // queue and counters only act when the stage really advances
  assign q_cmd = advance ? q_cmd_raw : '0;
  assign c_cmd = advance ? c_cmd_raw : '0;

  fiss_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (q_cmd),
    .frame_i  (in_frame),
    .stat_o   (q_stat),
    .first_o  (q_first),
    .second_o (q_second),
    .newest_o (q_newest)
  );

  fiss_counters u_counters (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (c_cmd),
    .counts_o (counts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ready_q     <= 1'b0;
      pause_q     <= 1'b0;
      gen_q       <= '0;
      synth_q     <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        ready_q <= ready_d;
        pause_q <= pause_d;
        gen_q   <= gen_d;
        synth_q <= synth_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_i.valid && in_ready) begin
      in_q <= req_i.data;
    end
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = rsp_q;

endmodule

// File: design/fiss_queue.sv
module fiss_queue import fiss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  queue_cmd_t  cmd_i,
  input  frame_t      frame_i,
  output queue_stat_t stat_o,
  output frame_t      first_o,
  output frame_t      second_o,
  output frame_t      newest_o
);

  // shift queue, slot 0 is always the oldest frame
  frame_t entry_q [QUEUE_DEPTH];
  frame_t entry_d [QUEUE_DEPTH];
  frame_t newest_q;
  logic [Q_CNT_W-1:0] count_q, count_d;
  logic full, empty, pair;

  assign full  = (count_q == Q_CNT_W'(QUEUE_DEPTH));
  assign empty = (count_q == '0);
  assign pair  = (count_q >= Q_CNT_W'(2));

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.push) begin
      if (full) begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          entry_d[i] = entry_q[i + 1];
        end
        entry_d[QUEUE_DEPTH - 1] = frame_i;
      end else begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (Q_CNT_W'(i) == count_q) begin
            entry_d[i] = frame_i;
          end
        end
      end
    end else if (cmd_i.pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        entry_d[i] = entry_q[i + 1];
      end
    end else if (cmd_i.trim) begin
      entry_d[0] = newest_q;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.push) begin
      if (!full) begin
        count_d = count_q + Q_CNT_W'(1);
      end
    end else if (cmd_i.pop) begin
      if (!empty) begin
        count_d = count_q - Q_CNT_W'(1);
      end
    end else if (cmd_i.trim) begin
      if (pair) begin
        count_d = Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (cmd_i.push) begin
      newest_q <= frame_i;
    end
  end

  assign stat_o.empty = empty;
  assign stat_o.pair  = pair;
  assign stat_o.full  = full;
  assign first_o      = entry_q[0];
  assign second_o     = entry_q[1];
  assign newest_o     = newest_q;

endmodule

// File: design/fiss_counters.sv
module fiss_counters import fiss_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctr_cmd_t             cmd_i,
  output logic [CNT_WIDTH-1:0] counts_o [NUM_CTR]
);

  logic [CNT_WIDTH-1:0] cnt_q [NUM_CTR];
  logic [CNT_WIDTH-1:0] cnt_d [NUM_CTR];

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clear) begin
      for (int i = 0; i < NUM_CTR; i++) begin
        cnt_d[i] = '0;
      end
    end else if (cmd_i.bump) begin
      // saturate at all ones
      if (cnt_q[cmd_i.sel] != '1) begin
        cnt_d[cmd_i.sel] = cnt_q[cmd_i.sel] + CNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CTR; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign counts_o = cnt_q;

endmodule

// File: design/fiss_checker.sv
`include "frame_interpolation_slot_scheduler_unit_assert.svh"

module fiss_checker import fiss_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input rsp_t rsp_data_i
);

  `FISS_ASSERT_HOLD(a_rsp_hold, clk_i, rst_ni, rsp_valid_i, rsp_ready_i, rsp_data_i, "stalled response beat changed")

  `FISS_ASSERT(a_slot_accepted, clk_i, rst_ni, (rsp_valid_i && (rsp_data_i.slot_kind != SLOT_SUSPEND)) |-> rsp_data_i.accepted, "slot answer not flagged accepted")

  `FISS_ASSERT(a_first_kind, clk_i, rst_ni, (rsp_valid_i && rsp_data_i.first_valid) |-> ((rsp_data_i.slot_kind == SLOT_NATIVE) || (rsp_data_i.slot_kind == SLOT_SOURCE) || (rsp_data_i.slot_kind == SLOT_SYNTH)), "frame a without a frame-carrying slot")

  `FISS_ASSERT(a_status_alone, clk_i, rst_ni, (rsp_valid_i && (rsp_data_i.status_value != '0)) |-> ((rsp_data_i.slot_kind == SLOT_SUSPEND) && !rsp_data_i.first_valid), "status value mixed with slot answer")

  `FISS_ASSERT(a_pair_frames, clk_i, rst_ni, (rsp_valid_i && ((rsp_data_i.slot_kind == SLOT_SOURCE) || (rsp_data_i.slot_kind == SLOT_SYNTH))) |-> (rsp_data_i.first_valid && (rsp_data_i.second_width != '0)), "pair slot without two frames")

endmodule

bind frame_interpolation_slot_scheduler_unit fiss_checker u_fiss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);
